// ----- rtl/chse_pkg.sv -----
// Shared types, codes and fixed-point helpers for the cubic Hermite spline evaluator.
package chse_pkg;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_EVAL   = 2'd2;

	localparam logic [1:0] OP_CLEAR  = 2'd0;
	localparam logic [1:0] OP_APPEND = 2'd1;
	localparam logic [1:0] OP_EVAL   = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_FEW    = 2'd1;
	localparam logic [1:0] STAT_ZERO_W = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	typedef logic signed [63:0] q64_t;

	// internal values are held within +-2^61
	localparam q64_t LIM = 64'sh2000_0000_0000_0000;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [31:0] pos;
		logic signed [31:0] value;
		logic signed [31:0] slope;
		logic signed [31:0] query;
	} chse_item_t;

	function automatic q64_t sat64(input q64_t v);
		if (v > LIM)
			return LIM;
		else if (v < -LIM)
			return -LIM;
		return v;
	endfunction

	// a * n for a small integer n, magnitude clamped to LIM
	function automatic q64_t kmul(input q64_t a, input logic [3:0] n);
		logic [63:0] mag;
		logic [67:0] m;
		logic [63:0] r;
		mag = a[63] ? 64'(-a) : 64'(a);
		m = 68'(mag) * 68'(n);
		if (m > 68'(LIM))
			m = 68'(LIM);
		r = m[63:0];
		return a[63] ? q64_t'(-r) : q64_t'(r);
	endfunction

	function automatic logic [31:0] out32(input q64_t v);
		if (v > 64'sd2147483647)
			return 32'h7fff_ffff;
		else if (v < -64'sd2147483648)
			return 32'h8000_0000;
		return v[31:0];
	endfunction

endpackage

// ----- rtl/chse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module chse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/chse_queue.sv -----
// Two-entry queue between the front and the back end.
module chse_queue import chse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  chse_item_t push_item,
	output logic       full,
	output logic       empty,
	input  logic       pop,
	output chse_item_t pop_item
);

	chse_item_t slot_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full     = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign pop_item = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ----- rtl/chse_front.sv -----
// Input stage: takes a beat, classifies the command and hands it to the queue.
module chse_front import chse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] knot_pos,
	input  logic signed [31:0] knot_value,
	input  logic signed [31:0] knot_slope,
	input  logic signed [31:0] query_pos,
	output logic               push,
	output chse_item_t         push_item,
	input  logic               q_full
);

	chse_item_t item_q;
	logic       valid_q;
	logic       accept;
	logic [1:0] op;

	always_comb begin
		case (command)
			CMD_CLEAR:  op = OP_CLEAR;
			CMD_APPEND: op = OP_APPEND;
			CMD_EVAL:   op = OP_EVAL;
			default:    op = OP_NOP;
		endcase
	end

	assign in_stall  = valid_q & q_full;
	assign accept    = in_valid & ~in_stall;
	assign push      = valid_q & ~q_full;
	assign push_item = item_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.op    <= op;
			item_q.pos   <= knot_pos;
			item_q.value <= knot_value;
			item_q.slope <= knot_slope;
			item_q.query <= query_pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= accept | (valid_q & ~push);
	end

endmodule

// ----- rtl/chse_mul.sv -----
// Sequential Q multiply: four 32x32 partial products, then shift and clamp.
module chse_mul import chse_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  q64_t a,
	input  q64_t b,
	output logic done,
	output q64_t res
);

	localparam int PW = 124;

	logic          busy_q;
	logic          fin_q;
	logic          done_q;
	logic [1:0]    cnt_q;
	logic [PW-1:0] acc_q;
	logic [61:0]   ua_q;
	logic [61:0]   ub_q;
	logic          neg_q;
	q64_t          res_q;

	logic [31:0]   pa;
	logic [31:0]   pb;
	logic [63:0]   prod;
	logic [PW-1:0] addend;
	logic [63:0]   ma;
	logic [63:0]   mb;
	logic [63:0]   r;
	logic          over;

	assign ma   = a[63] ? 64'(-a) : 64'(a);
	assign mb   = b[63] ? 64'(-b) : 64'(b);
	assign pa   = cnt_q[0] ? {2'b0, ua_q[61:32]} : ua_q[31:0];
	assign pb   = cnt_q[1] ? {2'b0, ub_q[61:32]} : ub_q[31:0];
	assign prod = pa * pb;

	always_comb begin
		case (cnt_q)
			2'd0:    addend = PW'(prod);
			2'd3:    addend = PW'(prod) << 64;
			default: addend = PW'(prod) << 32;
		endcase
	end

	assign over = |(acc_q >> (64 + FRAC_BITS));
	assign r    = 64'(acc_q >> FRAC_BITS);

	always_ff @(posedge clk) begin
		if (start) begin
			ua_q  <= ma[61:0];
			ub_q  <= mb[61:0];
			neg_q <= a[63] ^ b[63];
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_q + addend;
		end
		if (fin_q) begin
			if (over || r > 64'(LIM))
				res_q <= neg_q ? -LIM : LIM;
			else
				res_q <= neg_q ? q64_t'(-r) : q64_t'(r);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			done_q <= fin_q;
			fin_q  <= busy_q & (cnt_q == 2'd3);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 2'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 2'd1;
				if (cnt_q == 2'd3)
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- rtl/chse_div.sv -----
// Bit-serial restoring divide of a Q value by a positive 32-bit width.
module chse_div import chse_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  q64_t        a,
	input  logic [31:0] h,
	output logic        done,
	output q64_t        res
);

	localparam int NW = 62 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [NW-1:0] num_q;
	logic [31:0]   rem_q;
	logic [31:0]   h_q;
	logic          neg_q;

	logic [63:0]   ma;
	logic [32:0]   trial;
	logic          qbit;
	logic [63:0]   qc;

	assign ma    = a[63] ? 64'(-a) : 64'(a);
	assign trial = {rem_q, num_q[NW-1]};
	assign qbit  = (trial >= {1'b0, h_q});

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'(ma[61:0]) << FRAC_BITS;
			rem_q <= '0;
			h_q   <= h;
			neg_q <= a[63];
		end else if (busy_q) begin
			rem_q <= qbit ? 32'(trial - {1'b0, h_q}) : trial[31:0];
			num_q <= {num_q[NW-2:0], qbit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q & (cnt_q == CW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign qc   = (num_q > NW'(LIM)) ? 64'(LIM) : 64'(num_q);
	assign res  = neg_q ? q64_t'(-qc) : q64_t'(qc);
	assign done = done_q;

endmodule

// ----- rtl/chse_back.sv -----
// Back end: knot table, interval search, Hermite evaluation and result register.
module chse_back import chse_pkg::*; #(
	parameter int MAX_KNOTS = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	output logic               q_pop,
	input  chse_item_t         q_item,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] curve_value,
	output logic signed [31:0] curve_slope,
	output logic signed [31:0] curve_bend,
	output logic [5:0]         interval_index,
	output logic [1:0]         status
);

	localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int CW = $clog2(MAX_KNOTS + 1);
	localparam int SW = CW + 1;
	localparam q64_t ONE_Q = q64_t'(1) <<< FRAC_BITS;

	localparam logic [1:0] PH_VAL = 2'd0;
	localparam logic [1:0] PH_SLP = 2'd1;
	localparam logic [1:0] PH_BND = 2'd2;

	localparam logic [4:0] ST_IDLE     = 5'd0;
	localparam logic [4:0] ST_RD_FIRST = 5'd1;
	localparam logic [4:0] ST_CK_FIRST = 5'd2;
	localparam logic [4:0] ST_RD_LAST  = 5'd3;
	localparam logic [4:0] ST_CK_LAST  = 5'd4;
	localparam logic [4:0] ST_LOOP     = 5'd5;
	localparam logic [4:0] ST_RD_MID   = 5'd6;
	localparam logic [4:0] ST_CK_MID   = 5'd7;
	localparam logic [4:0] ST_RD_MID1  = 5'd8;
	localparam logic [4:0] ST_CK_MID1  = 5'd9;
	localparam logic [4:0] ST_RD_SEG   = 5'd10;
	localparam logic [4:0] ST_GET0     = 5'd11;
	localparam logic [4:0] ST_GET1     = 5'd12;
	localparam logic [4:0] ST_CHK_H    = 5'd13;
	localparam logic [4:0] ST_W_T      = 5'd14;
	localparam logic [4:0] ST_W_T2     = 5'd15;
	localparam logic [4:0] ST_W_T3     = 5'd16;
	localparam logic [4:0] ST_W_C2     = 5'd17;
	localparam logic [4:0] ST_W_C3     = 5'd18;
	localparam logic [4:0] ST_BL_GO    = 5'd19;
	localparam logic [4:0] ST_BL_W     = 5'd20;
	localparam logic [4:0] ST_PH_END   = 5'd21;
	localparam logic [4:0] ST_W_D1     = 5'd22;
	localparam logic [4:0] ST_W_D2     = 5'd23;
	localparam logic [4:0] ST_W_D3     = 5'd24;
	localparam logic [4:0] ST_OUT      = 5'd25;

	logic [4:0]           state_q;
	logic [CW-1:0]        n_q;
	logic signed [SW-1:0] lo_q;
	logic signed [SW-1:0] hi_q;
	logic [AW-1:0]        mid_q;
	logic [AW-1:0]        idx_q;
	logic signed [31:0]   x_q;
	logic signed [31:0]   p0_q;
	logic signed [31:0]   y0_q;
	logic signed [31:0]   s0_q;
	logic signed [31:0]   y1_q;
	logic signed [31:0]   s1_q;
	logic signed [32:0]   hd_q;
	q64_t                 t_q;
	q64_t                 t2_q;
	q64_t                 t3_q;
	q64_t                 c2_q;
	q64_t                 c3_q;
	q64_t                 acc_q;
	logic [1:0]           ph_q;
	logic [1:0]           j_q;
	logic [31:0]          r_val_q;
	logic [31:0]          r_slope_q;
	logic [31:0]          r_bend_q;
	logic [1:0]           r_status_q;
	logic                 ov_q;
	logic [31:0]          o_val_q;
	logic [31:0]          o_slope_q;
	logic [31:0]          o_bend_q;
	logic [5:0]           o_idx_q;
	logic [1:0]           o_status_q;

	logic                 we;
	logic [AW-1:0]        raddr;
	logic [31:0]          pos_rd;
	logic [31:0]          val_rd;
	logic [31:0]          slp_rd;
	logic signed [31:0]   pd;
	logic signed [SW-1:0] mid_s;
	logic signed [SW-1:0] nm2;
	logic signed [SW:0]   lh_sum;
	logic                 full;
	logic                 slot_free;

	logic                 mul_start;
	q64_t                 mul_a;
	q64_t                 mul_b;
	logic                 mul_done;
	q64_t                 mul_res;
	logic                 div_start;
	q64_t                 div_a;
	logic                 div_done;
	q64_t                 div_res;
	q64_t                 h64;
	q64_t                 cj;

	// Hermite basis and its derivatives, selected by phase and term
	function automatic q64_t weight(input logic [1:0] ph, input logic [1:0] j,
			input q64_t t, input q64_t t2, input q64_t t3);
		q64_t w;
		w = '0;
		case (ph)
			PH_VAL: begin
				case (j)
					2'd0:    w = sat64(sat64(kmul(t3, 4'd2) - kmul(t2, 4'd3)) + ONE_Q);
					2'd1:    w = sat64(kmul(t2, 4'd3) - kmul(t3, 4'd2));
					2'd2:    w = sat64(sat64(t3 - kmul(t2, 4'd2)) + t);
					default: w = sat64(t3 - t2);
				endcase
			end
			PH_SLP: begin
				case (j)
					2'd0:    w = sat64(kmul(t2, 4'd6) - kmul(t, 4'd6));
					2'd1:    w = sat64(kmul(t, 4'd6) - kmul(t2, 4'd6));
					2'd2:    w = sat64(sat64(kmul(t2, 4'd3) - kmul(t, 4'd4)) + ONE_Q);
					default: w = sat64(kmul(t2, 4'd3) - kmul(t, 4'd2));
				endcase
			end
			default: begin
				case (j)
					2'd0:    w = sat64(kmul(t, 4'd12) - kmul(ONE_Q, 4'd6));
					2'd1:    w = sat64(kmul(ONE_Q, 4'd6) - kmul(t, 4'd12));
					2'd2:    w = sat64(kmul(t, 4'd6) - kmul(ONE_Q, 4'd4));
					default: w = sat64(kmul(t, 4'd6) - kmul(ONE_Q, 4'd2));
				endcase
			end
		endcase
		return w;
	endfunction

	assign full      = (n_q >= CW'(MAX_KNOTS));
	assign we        = (state_q == ST_IDLE) & ~q_empty & (q_item.op == OP_APPEND) & ~full;
	assign q_pop     = (state_q == ST_IDLE) & ~q_empty;
	assign pd        = $signed(pos_rd);
	assign mid_s     = $signed(SW'(mid_q));
	assign nm2       = $signed(SW'(n_q) - SW'(2));
	assign lh_sum    = (SW+1)'(lo_q) + (SW+1)'(hi_q);
	assign h64       = q64_t'(64'(hd_q[31:0]));
	assign slot_free = ~ov_q | ~out_stall;

	always_comb begin
		case (state_q)
			ST_RD_LAST: raddr = AW'(n_q - CW'(1));
			ST_RD_MID:  raddr = mid_q;
			ST_RD_MID1: raddr = mid_q + AW'(1);
			ST_RD_SEG:  raddr = idx_q;
			ST_GET0:    raddr = idx_q + AW'(1);
			default:    raddr = '0;
		endcase
	end

	always_comb begin
		case (j_q)
			2'd0:    cj = 64'(y0_q);
			2'd1:    cj = 64'(y1_q);
			2'd2:    cj = c2_q;
			default: cj = c3_q;
		endcase
	end

	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_a     = '0;
		case (state_q)
			ST_CHK_H: begin
				div_start = (hd_q > 33'sd0);
				div_a     = 64'(x_q) - 64'(p0_q);
			end
			ST_W_T: begin
				mul_start = div_done;
				mul_a     = div_res;
				mul_b     = div_res;
			end
			ST_W_T2: begin
				mul_start = mul_done;
				mul_a     = mul_res;
				mul_b     = t_q;
			end
			ST_W_T3: begin
				mul_start = mul_done;
				mul_a     = h64;
				mul_b     = 64'(s0_q);
			end
			ST_W_C2: begin
				mul_start = mul_done;
				mul_a     = h64;
				mul_b     = 64'(s1_q);
			end
			ST_BL_GO: begin
				mul_start = 1'b1;
				mul_a     = cj;
				mul_b     = weight(ph_q, j_q, t_q, t2_q, t3_q);
			end
			ST_PH_END: begin
				div_start = (ph_q != PH_VAL);
				div_a     = acc_q;
			end
			ST_W_D2: begin
				div_start = div_done;
				div_a     = div_res;
			end
			default: ;
		endcase
	end

	chse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_pos_ram (
		.clk(clk), .we(we), .waddr(AW'(n_q)), .wdata(q_item.pos),
		.raddr(raddr), .rdata(pos_rd)
	);

	chse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_val_ram (
		.clk(clk), .we(we), .waddr(AW'(n_q)), .wdata(q_item.value),
		.raddr(raddr), .rdata(val_rd)
	);

	chse_ram #(.WIDTH(32), .DEPTH(MAX_KNOTS)) u_slp_ram (
		.clk(clk), .we(we), .waddr(AW'(n_q)), .wdata(q_item.slope),
		.raddr(raddr), .rdata(slp_rd)
	);

	chse_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .res(mul_res)
	);

	chse_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(div_a), .h(hd_q[31:0]),
		.done(div_done), .res(div_res)
	);

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q        <= q_item.query;
				idx_q      <= '0;
				r_val_q    <= '0;
				r_slope_q  <= '0;
				r_bend_q   <= '0;
				if (!q_empty && q_item.op == OP_APPEND && full)
					r_status_q <= STAT_FULL;
				else if (!q_empty && q_item.op == OP_EVAL && n_q < CW'(2))
					r_status_q <= STAT_FEW;
				else
					r_status_q <= STAT_OK;
			end
			ST_CK_FIRST: idx_q <= '0;
			ST_CK_LAST: begin
				idx_q <= nm2[AW-1:0];
				lo_q  <= '0;
				hi_q  <= nm2;
			end
			ST_LOOP: begin
				mid_q <= lh_sum[AW:1];
				idx_q <= (lo_q > nm2) ? nm2[AW-1:0] : lo_q[AW-1:0];
			end
			ST_CK_MID: begin
				if (x_q < pd)
					hi_q <= mid_s - SW'(1);
			end
			ST_CK_MID1: begin
				lo_q  <= mid_s + SW'(1);
				idx_q <= mid_q;
			end
			ST_GET0: begin
				p0_q <= pd;
				y0_q <= $signed(val_rd);
				s0_q <= $signed(slp_rd);
			end
			ST_GET1: begin
				hd_q <= 33'(pd) - 33'(p0_q);
				y1_q <= $signed(val_rd);
				s1_q <= $signed(slp_rd);
			end
			ST_CHK_H: begin
				if (hd_q <= 33'sd0)
					r_status_q <= STAT_ZERO_W;
			end
			ST_W_T:  if (div_done) t_q <= div_res;
			ST_W_T2: if (mul_done) t2_q <= mul_res;
			ST_W_T3: if (mul_done) t3_q <= mul_res;
			ST_W_C2: if (mul_done) c2_q <= mul_res;
			ST_W_C3: begin
				if (mul_done) begin
					c3_q  <= mul_res;
					acc_q <= '0;
					j_q   <= 2'd0;
					ph_q  <= PH_VAL;
				end
			end
			ST_BL_W: begin
				if (mul_done) begin
					acc_q <= sat64(acc_q + mul_res);
					j_q   <= j_q + 2'd1;
				end
			end
			ST_PH_END: begin
				if (ph_q == PH_VAL) begin
					r_val_q <= out32(acc_q);
					ph_q    <= PH_SLP;
					acc_q   <= '0;
				end
			end
			ST_W_D1: begin
				if (div_done) begin
					r_slope_q <= out32(div_res);
					ph_q      <= PH_BND;
					acc_q     <= '0;
				end
			end
			ST_W_D3: if (div_done) r_bend_q <= out32(div_res);
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && slot_free) begin
			o_val_q    <= r_val_q;
			o_slope_q  <= r_slope_q;
			o_bend_q   <= r_bend_q;
			o_idx_q    <= 6'(idx_q);
			o_status_q <= r_status_q;
		end
	end

	// sequencer, knot count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			ov_q <= (state_q == ST_OUT && slot_free) || (ov_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						case (q_item.op)
							OP_CLEAR: begin
								n_q     <= '0;
								state_q <= ST_OUT;
							end
							OP_APPEND: begin
								if (!full)
									n_q <= n_q + CW'(1);
								state_q <= ST_OUT;
							end
							OP_EVAL: state_q <= (n_q >= CW'(2)) ? ST_RD_FIRST : ST_OUT;
							default: state_q <= ST_OUT;
						endcase
					end
				end
				ST_RD_FIRST: state_q <= ST_CK_FIRST;
				ST_CK_FIRST: state_q <= (x_q <= pd) ? ST_RD_SEG : ST_RD_LAST;
				ST_RD_LAST:  state_q <= ST_CK_LAST;
				ST_CK_LAST:  state_q <= (x_q >= pd) ? ST_RD_SEG : ST_LOOP;
				ST_LOOP:     state_q <= (lo_q <= hi_q) ? ST_RD_MID : ST_RD_SEG;
				ST_RD_MID:   state_q <= ST_CK_MID;
				ST_CK_MID:   state_q <= (x_q < pd) ? ST_LOOP : ST_RD_MID1;
				ST_RD_MID1:  state_q <= ST_CK_MID1;
				ST_CK_MID1:  state_q <= (x_q > pd) ? ST_LOOP : ST_RD_SEG;
				ST_RD_SEG:   state_q <= ST_GET0;
				ST_GET0:     state_q <= ST_GET1;
				ST_GET1:     state_q <= ST_CHK_H;
				ST_CHK_H:    state_q <= (hd_q > 33'sd0) ? ST_W_T : ST_OUT;
				ST_W_T:      if (div_done) state_q <= ST_W_T2;
				ST_W_T2:     if (mul_done) state_q <= ST_W_T3;
				ST_W_T3:     if (mul_done) state_q <= ST_W_C2;
				ST_W_C2:     if (mul_done) state_q <= ST_W_C3;
				ST_W_C3:     if (mul_done) state_q <= ST_BL_GO;
				ST_BL_GO:    state_q <= ST_BL_W;
				ST_BL_W: begin
					if (mul_done)
						state_q <= (j_q == 2'd3) ? ST_PH_END : ST_BL_GO;
				end
				ST_PH_END: begin
					case (ph_q)
						PH_VAL:  state_q <= ST_BL_GO;
						PH_SLP:  state_q <= ST_W_D1;
						default: state_q <= ST_W_D2;
					endcase
				end
				ST_W_D1: if (div_done) state_q <= ST_BL_GO;
				ST_W_D2: if (div_done) state_q <= ST_W_D3;
				ST_W_D3: if (div_done) state_q <= ST_OUT;
				ST_OUT: begin
					if (slot_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid      = ov_q;
	assign curve_value    = $signed(o_val_q);
	assign curve_slope    = $signed(o_slope_q);
	assign curve_bend     = $signed(o_bend_q);
	assign interval_index = o_idx_q;
	assign status         = o_status_q;

endmodule

// ----- rtl/cubic_hermite_spline_eval_core.sv -----
// Top level of the cubic Hermite spline evaluator: front stage, queue and back end.
//
//   channel  signals                                         role
//   in       in_valid/in_stall, command, knot_*, query_pos   command beats
//   out      out_valid/out_stall, curve_*, interval_index,   one result beat per command
//            status
//
// Clear, append and unknown commands go from the idle state straight to the output state.
// Evaluate: interval search and knot fetch, four serial divides and sixteen multiplies.
// The bit-serial divider sets the evaluate time. The knot table needs no clearing pass.
// arst_n clears control state; a stalled output holds its beat while the front keeps
// accepting until the two-entry queue and the input register are full.
module cubic_hermite_spline_eval_core import chse_pkg::*; #(
	parameter int MAX_KNOTS = 64,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] knot_pos,
	input  logic signed [31:0] knot_value,
	input  logic signed [31:0] knot_slope,
	input  logic signed [31:0] query_pos,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] curve_value,
	output logic signed [31:0] curve_slope,
	output logic signed [31:0] curve_bend,
	output logic [5:0]         interval_index,
	output logic [1:0]         status
);

	logic       push;
	chse_item_t push_item;
	logic       q_full;
	logic       q_empty;
	logic       q_pop;
	chse_item_t q_item;

	chse_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.command(command), .knot_pos(knot_pos), .knot_value(knot_value),
		.knot_slope(knot_slope), .query_pos(query_pos),
		.push(push), .push_item(push_item), .q_full(q_full)
	);

	chse_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_item(push_item),
		.full(q_full), .empty(q_empty), .pop(q_pop), .pop_item(q_item)
	);

	chse_back #(.MAX_KNOTS(MAX_KNOTS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_empty(q_empty), .q_pop(q_pop), .q_item(q_item),
		.out_valid(out_valid), .out_stall(out_stall),
		.curve_value(curve_value), .curve_slope(curve_slope), .curve_bend(curve_bend),
		.interval_index(interval_index), .status(status)
	);

endmodule
